@@ sv/area_average_downscaler_macros.svh @@
// Assertion helpers for the downscaler files
`ifndef AREA_AVERAGE_DOWNSCALER_MACROS_SVH
`define AREA_AVERAGE_DOWNSCALER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define ADS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("downscaler assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define ADS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("downscaler assertion failed");

`endif

@@ sv/ads_pkg.sv @@
package ads_pkg;

  // Default sizes
  localparam int unsigned DEF_MAX_SOURCE_WIDTH  = 8192;
  localparam int unsigned DEF_MAX_SOURCE_HEIGHT = 8192;
  localparam int unsigned DEF_MAX_TARGET_WIDTH  = 4096;
  localparam int unsigned DEF_CHANNEL_BITS      = 16;

  // Fixed widths
  localparam int unsigned DIM_W   = 15;  // internal dimension width
  localparam int unsigned SUM_W   = 42;  // per-channel sum
  localparam int unsigned CNT_W   = 27;  // pixel count
  localparam int unsigned SRCW_W  = 14;
  localparam int unsigned SRCH_W  = 14;
  localparam int unsigned TGTW_W  = 13;
  localparam int unsigned TGTH_W  = 14;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CIDX_W  = 2;

  // Register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } reg_idx_e;

endpackage

@@ sv/area_average_downscaler.sv @@
// Area-average downscaler for a raster stream of linear RGB pixels.
// Source pixels enter on s_axis (tdata: red, green, blue from bit 0 up);
// each destination pixel is the rounded mean of its source cell and leaves
// on m_axis, with tlast high on the final destination pixel of the frame.
// Sizes are set through the plain write port (index 0 source width,
// 1 source height, 2 target width, 3 target height); any write restarts the
// frame and drops partial cells.
// Per-column sums and counts sit in one single-port-read line RAM, so each
// source pixel is handled as a read, then the add and write-back.
// A pixel that closes a cell then runs through the shared bit-serial
// divider (S_DIV) and S_OUT, which loads the result into the output
// register once that register is free or being taken.
// After reset and after every register write the block works out the
// cell step sizes in S_CFG, with s_axis_tready low.
// While the output register holds an unaccepted result the block keeps
// taking pixels; a second result waits in the divider until m_axis frees.
module area_average_downscaler
  import ads_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned MAX_TARGET_WIDTH  = DEF_MAX_TARGET_WIDTH,
  parameter int unsigned CHANNEL_BITS      = DEF_CHANNEL_BITS,
  localparam int unsigned DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // red_in, green_in, blue_in, zero pad
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out, zero pad
  output logic              m_axis_tlast    // frame_last
);

`include "area_average_downscaler_macros.svh"

  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned AW     = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
  localparam int unsigned ENT_W  = 3 * SUM_W + CNT_W;
  localparam int unsigned DCNT_W = $clog2(CB + 1);
  localparam int unsigned CCNT_W = $clog2(DIM_W + 1);
  localparam int unsigned PAD_W  = DATA_W - 3 * CB;

  typedef enum logic [2:0] {S_CFG, S_IDLE, S_MOD, S_DIV, S_OUT} state_e;

  // Restoring division step for the config-time step sizes
  function automatic logic [2*DIM_W:0] cdiv_step(logic [DIM_W:0] rem, logic [DIM_W-1:0] num,
                                                 logic [DIM_W-1:0] den);
    logic [DIM_W:0] t;
    logic           bit_v;
    t = {rem[DIM_W-1:0], num[DIM_W-1]};
    bit_v = 1'b0;
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      bit_v = 1'b1;
    end
    return {t, num[DIM_W-2:0], bit_v};
  endfunction

  // Restoring division step for the averages
  function automatic logic [CNT_W+CB:0] adiv_step(logic [CNT_W:0] rem, logic [CB-1:0] num,
                                                  logic [CNT_W-1:0] den);
    logic [CNT_W:0] t;
    logic           bit_v;
    t = {rem[CNT_W-1:0], num[CB-1]};
    bit_v = 1'b0;
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      bit_v = 1'b1;
    end
    if (CB > 1) begin
      return {t, num[CB-2:0], bit_v};
    end else begin
      return {t, bit_v};
    end
  endfunction

  // Configuration registers
  logic [SRCW_W-1:0] src_w_q;
  logic [SRCH_W-1:0] src_h_q;
  logic [TGTW_W-1:0] tgt_w_q;
  logic [TGTH_W-1:0] tgt_h_q;

  // Effective sizes
  logic [DIM_W-1:0] eff_w, eff_h, eff_dw, eff_dh, max_dw;
  always_comb begin
    if (src_w_q == '0) eff_w = DIM_W'(1);
    else if (DIM_W'(src_w_q) > DIM_W'(MAX_SOURCE_WIDTH)) eff_w = DIM_W'(MAX_SOURCE_WIDTH);
    else eff_w = DIM_W'(src_w_q);
    if (src_h_q == '0) eff_h = DIM_W'(1);
    else if (DIM_W'(src_h_q) > DIM_W'(MAX_SOURCE_HEIGHT)) eff_h = DIM_W'(MAX_SOURCE_HEIGHT);
    else eff_h = DIM_W'(src_h_q);
    max_dw = (eff_w < DIM_W'(MAX_TARGET_WIDTH)) ? eff_w : DIM_W'(MAX_TARGET_WIDTH);
    if (tgt_w_q == '0) eff_dw = DIM_W'(1);
    else if (DIM_W'(tgt_w_q) > max_dw) eff_dw = max_dw;
    else eff_dw = DIM_W'(tgt_w_q);
    if (tgt_h_q == '0) eff_dh = DIM_W'(1);
    else if (DIM_W'(tgt_h_q) > eff_h) eff_dh = eff_h;
    else eff_dh = DIM_W'(tgt_h_q);
  end

  state_e state_q;

  // Step sizes: cell width quotient and remainder per axis
  logic [CCNT_W-1:0] ccnt_q;
  logic [DIM_W:0]    cw_rem_q, ch_rem_q;
  logic [DIM_W-1:0]  cw_num_q, ch_num_q;
  logic [2*DIM_W:0]  cw_step, ch_step;
  logic [DIM_W-1:0]  qw_q, rw_q, qh_q, rh_q;

  assign cw_step = cdiv_step(cw_rem_q, cw_num_q, eff_dw);
  assign ch_step = cdiv_step(ch_rem_q, ch_num_q, eff_dh);

  // Position state
  logic [DIM_W-1:0] src_col_q, src_row_q, tgt_col_q, tgt_row_q;
  logic [DIM_W-1:0] col_bnd_q, row_bnd_q, col_rem_q, row_rem_q;
  logic             first_row_q, first_col_q;

  // Item latched at accept
  logic [2:0][CB-1:0] pix_q;
  logic init_q, col_end_q, row_end_q, line_end_q, frame_end_q;

  // Next cell bounds
  logic [DIM_W:0]   col_rsum, row_rsum;
  logic [DIM_W-1:0] col_bnd_nx, col_rem_nx, row_bnd_nx, row_rem_nx;
  always_comb begin
    col_rsum = {1'b0, col_rem_q} + {1'b0, rw_q};
    if (col_rsum >= {1'b0, eff_dw}) begin
      col_rem_nx = DIM_W'(col_rsum - {1'b0, eff_dw});
      col_bnd_nx = col_bnd_q + qw_q + DIM_W'(1);
    end else begin
      col_rem_nx = DIM_W'(col_rsum);
      col_bnd_nx = col_bnd_q + qw_q;
    end
    row_rsum = {1'b0, row_rem_q} + {1'b0, rh_q};
    if (row_rsum >= {1'b0, eff_dh}) begin
      row_rem_nx = DIM_W'(row_rsum - {1'b0, eff_dh});
      row_bnd_nx = row_bnd_q + qh_q + DIM_W'(1);
    end else begin
      row_rem_nx = DIM_W'(row_rsum);
      row_bnd_nx = row_bnd_q + qh_q;
    end
  end

  // Line RAM: {count, blue, green, red sums}
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  ads_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TARGET_WIDTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ram_re        = accept;
  assign ram_we        = (state_q == S_MOD);
  assign ram_addr      = tgt_col_q[AW-1:0];

  // Accumulate
  logic [2:0][SUM_W-1:0] new_sum;
  logic [CNT_W-1:0]      new_cnt;
  logic [2:0][SUM_W:0]   rnd_sum;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (init_q) new_sum[c] = SUM_W'(pix_q[c]);
      else new_sum[c] = ram_rdata[c*SUM_W +: SUM_W] + SUM_W'(pix_q[c]);
      rnd_sum[c] = {1'b0, new_sum[c]};
    end
    new_cnt = init_q ? CNT_W'(1) : ram_rdata[3*SUM_W +: CNT_W] + CNT_W'(1);
    for (int c = 0; c < 3; c++) begin
      rnd_sum[c] = rnd_sum[c] + (SUM_W + 1)'(new_cnt >> 1);
    end
  end
  assign ram_wdata = {new_cnt, new_sum[2], new_sum[1], new_sum[0]};

  // Average divider
  logic [DCNT_W-1:0]     dcnt_q;
  logic [CNT_W-1:0]      dden_q;
  logic [2:0][CNT_W:0]   drem_q;
  logic [2:0][CB-1:0]    dnum_q;
  logic [2:0][CNT_W+CB:0] dstep;
  logic                  dlast_q;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dstep[c] = adiv_step(drem_q[c], dnum_q[c], dden_q);
    end
  end

  // Output register
  logic [2:0][CB-1:0] out_q;
  logic               m_valid_q, m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q     <= SRCW_W'(1);
      src_h_q     <= SRCH_W'(1);
      tgt_w_q     <= TGTW_W'(1);
      tgt_h_q     <= TGTH_W'(1);
      state_q     <= S_CFG;
      ccnt_q      <= '0;
      cw_rem_q    <= '0;
      ch_rem_q    <= '0;
      cw_num_q    <= '0;
      ch_num_q    <= '0;
      qw_q        <= DIM_W'(1);
      rw_q        <= '0;
      qh_q        <= DIM_W'(1);
      rh_q        <= '0;
      src_col_q   <= '0;
      src_row_q   <= '0;
      tgt_col_q   <= '0;
      tgt_row_q   <= '0;
      col_bnd_q   <= DIM_W'(1);
      row_bnd_q   <= DIM_W'(1);
      col_rem_q   <= '0;
      row_rem_q   <= '0;
      first_row_q <= 1'b1;
      first_col_q <= 1'b1;
      pix_q       <= '0;
      init_q      <= 1'b0;
      col_end_q   <= 1'b0;
      row_end_q   <= 1'b0;
      line_end_q  <= 1'b0;
      frame_end_q <= 1'b0;
      dcnt_q      <= '0;
      dden_q      <= '0;
      drem_q      <= '0;
      dnum_q      <= '0;
      dlast_q     <= 1'b0;
      out_q       <= '0;
      m_valid_q   <= 1'b0;
      m_last_q    <= 1'b0;
    end else begin
      // Result taken; S_OUT reloads the register itself when it runs
      if (m_valid_q && m_axis_tready && !(state_q == S_OUT && !cfg_we_i)) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        // Register writes restart the frame
        case (cfg_index_i)
          REG_SOURCE_WIDTH: begin
            src_w_q <= cfg_wdata_i[SRCW_W-1:0];
            state_q <= S_CFG;
            ccnt_q  <= '0;
          end
          REG_SOURCE_HEIGHT: begin
            src_h_q <= cfg_wdata_i[SRCH_W-1:0];
            state_q <= S_CFG;
            ccnt_q  <= '0;
          end
          REG_TARGET_WIDTH: begin
            tgt_w_q <= cfg_wdata_i[TGTW_W-1:0];
            state_q <= S_CFG;
            ccnt_q  <= '0;
          end
          REG_TARGET_HEIGHT: begin
            tgt_h_q <= cfg_wdata_i[TGTH_W-1:0];
            state_q <= S_CFG;
            ccnt_q  <= '0;
          end
          default: begin
          end
        endcase
      end else begin
        case (state_q)
          // Work out cell step sizes, then restart the frame
          S_CFG: begin
            if (ccnt_q == '0) begin
              cw_num_q <= eff_w;
              ch_num_q <= eff_h;
              cw_rem_q <= '0;
              ch_rem_q <= '0;
              ccnt_q   <= ccnt_q + CCNT_W'(1);
            end else begin
              cw_rem_q <= cw_step[2*DIM_W:DIM_W];
              cw_num_q <= cw_step[DIM_W-1:0];
              ch_rem_q <= ch_step[2*DIM_W:DIM_W];
              ch_num_q <= ch_step[DIM_W-1:0];
              if (ccnt_q == CCNT_W'(DIM_W)) begin
                qw_q        <= cw_step[DIM_W-1:0];
                rw_q        <= cw_step[2*DIM_W-1:DIM_W];
                qh_q        <= ch_step[DIM_W-1:0];
                rh_q        <= ch_step[2*DIM_W-1:DIM_W];
                col_bnd_q   <= cw_step[DIM_W-1:0];
                col_rem_q   <= cw_step[2*DIM_W-1:DIM_W];
                row_bnd_q   <= ch_step[DIM_W-1:0];
                row_rem_q   <= ch_step[2*DIM_W-1:DIM_W];
                src_col_q   <= '0;
                src_row_q   <= '0;
                tgt_col_q   <= '0;
                tgt_row_q   <= '0;
                first_row_q <= 1'b1;
                first_col_q <= 1'b1;
                ccnt_q      <= '0;
                state_q     <= S_IDLE;
              end else begin
                ccnt_q      <= ccnt_q + CCNT_W'(1);
              end
            end
          end

          // Take a pixel, read its column entry
          S_IDLE: begin
            if (accept) begin
              for (int c = 0; c < 3; c++) begin
                pix_q[c] <= s_axis_tdata[c*CB +: CB];
              end
              init_q      <= first_row_q && first_col_q;
              col_end_q   <= (src_col_q + DIM_W'(1)) >= col_bnd_q;
              row_end_q   <= (src_row_q + DIM_W'(1)) >= row_bnd_q;
              line_end_q  <= (src_col_q + DIM_W'(1)) >= eff_w;
              frame_end_q <= ((src_col_q + DIM_W'(1)) >= eff_w) &&
                             ((src_row_q + DIM_W'(1)) >= eff_h);
              state_q     <= S_MOD;
            end
          end

          // Write back, step position, start divider on cell end
          S_MOD: begin
            if (frame_end_q) begin
              src_col_q   <= '0;
              src_row_q   <= '0;
              tgt_col_q   <= '0;
              tgt_row_q   <= '0;
              col_bnd_q   <= qw_q;
              col_rem_q   <= rw_q;
              row_bnd_q   <= qh_q;
              row_rem_q   <= rh_q;
              first_row_q <= 1'b1;
              first_col_q <= 1'b1;
            end else if (line_end_q) begin
              src_col_q   <= '0;
              tgt_col_q   <= '0;
              col_bnd_q   <= qw_q;
              col_rem_q   <= rw_q;
              first_col_q <= 1'b1;
              src_row_q   <= src_row_q + DIM_W'(1);
              if (row_end_q) begin
                tgt_row_q   <= tgt_row_q + DIM_W'(1);
                row_bnd_q   <= row_bnd_nx;
                row_rem_q   <= row_rem_nx;
                first_row_q <= 1'b1;
              end else begin
                first_row_q <= 1'b0;
              end
            end else begin
              src_col_q <= src_col_q + DIM_W'(1);
              if (col_end_q) begin
                tgt_col_q   <= tgt_col_q + DIM_W'(1);
                col_bnd_q   <= col_bnd_nx;
                col_rem_q   <= col_rem_nx;
                first_col_q <= 1'b1;
              end else begin
                first_col_q <= 1'b0;
              end
            end

            if (col_end_q && row_end_q) begin
              for (int c = 0; c < 3; c++) begin
                drem_q[c] <= (CNT_W + 1)'(rnd_sum[c] >> CB);
                dnum_q[c] <= rnd_sum[c][CB-1:0];
              end
              dden_q  <= new_cnt;
              dlast_q <= frame_end_q;
              dcnt_q  <= '0;
              state_q <= S_DIV;
            end else begin
              state_q <= S_IDLE;
            end
          end

          // One quotient bit per cycle for all three channels
          S_DIV: begin
            for (int c = 0; c < 3; c++) begin
              drem_q[c] <= dstep[c][CNT_W+CB:CB];
              dnum_q[c] <= dstep[c][CB-1:0];
            end
            dcnt_q <= dcnt_q + DCNT_W'(1);
            if (dcnt_q == DCNT_W'(CB - 1)) begin
              state_q <= S_OUT;
            end
          end

          // Hand the result to the output register
          S_OUT: begin
            if (!m_valid_q || m_axis_tready) begin
              out_q     <= dnum_q;
              m_last_q  <= dlast_q;
              m_valid_q <= 1'b1;
              state_q   <= S_IDLE;
            end
          end

          default: begin
            state_q <= S_CFG;
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  generate
    if (PAD_W > 0) begin : g_pad
      assign m_axis_tdata = {PAD_W'(0), out_q[2], out_q[1], out_q[0]};
    end else begin : g_nopad
      assign m_axis_tdata = {out_q[2], out_q[1], out_q[0]};
    end
  endgenerate

  // Checks
  `ADS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ADS_ASSERT_IMP(a_mod_after_read, state_q == S_MOD, $past(state_q) == S_IDLE)
  `ADS_ASSERT_IMP(a_col_inside_cell, state_q == S_IDLE, col_bnd_q > src_col_q)
  `ADS_ASSERT_IMP(a_div_nonzero, state_q == S_DIV, dden_q != '0)

endmodule

@@ sv/ads_ram.sv @@
module ads_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
